>>> src/tse_pkg.sv
// Shared constants, types and command/status bundles of the topological sort engine.
`default_nettype none
package tse_pkg;
    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int EDGE_W    = $clog2(MAX_EDGES);
    localparam int PTR_W     = EDGE_W + 1;
    localparam int DEG_W     = EDGE_W + 1;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(MAX_EDGES);
    localparam logic [CNT_W-1:0] NC_MIN   = CNT_W'(2);
    localparam logic [CNT_W-1:0] NC_MAX   = CNT_W'(MAX_NODES);

    typedef struct packed {
        logic run_start;
        logic load1;
        logic load2;
        logic reject;
        logic scan_step;
        logic scan_emit;
        logic sel_scan;
        logic pop;
        logic popw;
        logic fetch;
        logic dec;
        logic emit_child;
        logic summary;
    } cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic out_free;
        logic scan_done;
        logic scan_zero;
        logic sp_zero;
        logic sp_gt1;
        logic top_null;
        logic t_out_range;
        logic d_zero;
        logic d_one;
        logic can_push;
    } stat_t;
endpackage
`default_nettype wire

>>> src/tse_ram.sv
// Generic simple dual-port RAM with registered, read-first output.
`default_nettype none
module tse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> src/tse_ctrl.sv
// Sequencer of the topological sort engine: edge loads and the depth-first run.
`default_nettype none
module tse_ctrl import tse_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  in_action,
    output logic       in_ready,
    input  wire stat_t st,
    output cmd_t       cmd
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_LOAD2 = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_SCANE = 10'b0000001000,
        S_WALK  = 10'b0000010000,
        S_POPW  = 10'b0000100000,
        S_FETCH = 10'b0001000000,
        S_DEC   = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_SUMM  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_action)
                    begin
                        cmd.run_start = 1'b1;
                        state_next    = S_SCAN;
                    end
                    else if (st.edge_ok)
                    begin
                        cmd.load1  = 1'b1;
                        state_next = S_LOAD2;
                    end
                    else
                    begin
                        cmd.reject = 1'b1;
                    end
                end
            end
            S_LOAD2:
            begin
                cmd.load2  = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.sel_scan = 1'b1;
                if (st.scan_done)
                begin
                    state_next = S_SUMM;
                end
                else if (st.scan_zero)
                begin
                    state_next = S_SCANE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SCANE:
            begin
                cmd.sel_scan = 1'b1;
                if (st.out_free)
                begin
                    cmd.scan_emit = 1'b1;
                    state_next    = S_WALK;
                end
            end
            S_WALK:
            begin
                if (st.sp_zero)
                begin
                    state_next = S_SCAN;
                end
                else if (st.top_null)
                begin
                    cmd.pop    = 1'b1;
                    state_next = st.sp_gt1 ? S_POPW : S_SCAN;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_POPW:
            begin
                cmd.popw   = 1'b1;
                state_next = S_WALK;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = st.t_out_range ? S_WALK : S_DEC;
            end
            S_DEC:
            begin
                if (st.d_zero)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    cmd.dec    = 1'b1;
                    state_next = (st.d_one && st.can_push) ? S_EMIT : S_WALK;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit_child = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_SUMM:
            begin
                if (st.out_free)
                begin
                    cmd.summary = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> src/tse_dp.sv
// Datapath of the topological sort engine: graph store, frame stack, counters, result register.
`default_nettype none
module tse_dp import tse_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output stat_t                  st,
    input  wire logic              cfg_we,
    input  wire logic [CNT_W-1:0]  cfg_value,
    input  wire logic [NODE_W-1:0] in_src,
    input  wire logic [NODE_W-1:0] in_tgt,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [NODE_W-1:0]      out_node,
    output logic                   out_summary,
    output logic [NODE_W-1:0]      out_count,
    output logic                   out_cycle,
    output logic                   out_error,
    output logic                   out_last
);
    logic [CNT_W-1:0]     node_count_reg;
    logic [DEG_W-1:0]     edges_used_reg;
    logic                 error_reg;
    logic [MAX_NODES-1:0] head_valid_reg;
    logic [MAX_NODES-1:0] hit_reg;
    logic [NODE_W-1:0]    s_reg;
    logic [NODE_W-1:0]    t_reg;
    logic [EDGE_W-1:0]    e_reg;
    logic [CNT_W-1:0]     scan_reg;
    logic [CNT_W-1:0]     sp_reg;
    logic [PTR_W-1:0]     top_reg;
    logic [NODE_W-1:0]    emitted_reg;
    logic                 out_valid_reg;

    logic [CNT_W-1:0]  nc;
    logic [NODE_W-1:0] tgt_rd;
    logic [PTR_W-1:0]  nxt_rd;
    logic [EDGE_W-1:0] head_rd;
    logic [EDGE_W-1:0] tail_rd;
    logic [DEG_W-1:0]  deg_rd;
    logic [PTR_W-1:0]  stk_rd;
    logic [DEG_W-1:0]  deg_cur;
    logic [NODE_W-1:0] head_addr;
    logic [PTR_W-1:0]  head_ptr;
    logic              nxt_we;
    logic [EDGE_W-1:0] nxt_waddr;
    logic [PTR_W-1:0]  nxt_wdata;
    logic              deg_we;
    logic [DEG_W-1:0]  deg_wdata;
    logic [NODE_W-1:0] deg_raddr;
    logic [CNT_W-1:0]  sp_m1;
    logic [CNT_W-1:0]  sp_m2;
    logic              emit;

    // Clamp the node count register into its legal range
    always_comb
    begin
        if (node_count_reg < NC_MIN)
        begin
            nc = NC_MIN;
        end
        else if (node_count_reg > NC_MAX)
        begin
            nc = NC_MAX;
        end
        else
        begin
            nc = node_count_reg;
        end
    end

    assign sp_m1     = sp_reg - CNT_W'(1);
    assign sp_m2     = sp_reg - CNT_W'(2);
    assign head_addr = cmd.sel_scan ? scan_reg[NODE_W-1:0] : t_reg;
    assign head_ptr  = head_valid_reg[head_addr] ? {1'b0, head_rd} : NULL_PTR;
    assign deg_cur   = hit_reg[t_reg] ? deg_rd : '0;
    assign deg_raddr = cmd.fetch ? tgt_rd : in_tgt;

    assign nxt_we    = cmd.load1 || (cmd.load2 && head_valid_reg[s_reg]);
    assign nxt_waddr = cmd.load1 ? edges_used_reg[EDGE_W-1:0] : tail_rd;
    assign nxt_wdata = cmd.load1 ? NULL_PTR : {1'b0, e_reg};
    assign deg_we    = cmd.load2 || cmd.dec;
    assign deg_wdata = cmd.load2 ? (deg_cur + DEG_W'(1)) : (deg_cur - DEG_W'(1));

    tse_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_tgt (
        .clk   (clk),
        .we    (cmd.load1),
        .waddr (edges_used_reg[EDGE_W-1:0]),
        .wdata (in_tgt),
        .raddr (top_reg[EDGE_W-1:0]),
        .rdata (tgt_rd)
    );

    tse_ram #(.WIDTH(PTR_W), .DEPTH(MAX_EDGES)) u_nxt (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (top_reg[EDGE_W-1:0]),
        .rdata (nxt_rd)
    );

    tse_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_NODES)) u_head (
        .clk   (clk),
        .we    (cmd.load2 && !head_valid_reg[s_reg]),
        .waddr (s_reg),
        .wdata (e_reg),
        .raddr (head_addr),
        .rdata (head_rd)
    );

    tse_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_NODES)) u_tail (
        .clk   (clk),
        .we    (cmd.load2),
        .waddr (s_reg),
        .wdata (e_reg),
        .raddr (in_src),
        .rdata (tail_rd)
    );

    tse_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg (
        .clk   (clk),
        .we    (deg_we),
        .waddr (t_reg),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rd)
    );

    tse_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_stack (
        .clk   (clk),
        .we    (cmd.emit_child),
        .waddr (sp_m1[NODE_W-1:0]),
        .wdata (top_reg),
        .raddr (sp_m2[NODE_W-1:0]),
        .rdata (stk_rd)
    );

    always_comb
    begin
        st.edge_ok     = (edges_used_reg != DEG_W'(MAX_EDGES))
                         && (in_src != '0) && (in_tgt != '0)
                         && ({1'b0, in_src} < nc) && ({1'b0, in_tgt} < nc);
        st.out_free    = !out_valid_reg || out_ready;
        st.scan_done   = (scan_reg >= nc);
        st.scan_zero   = !hit_reg[scan_reg[NODE_W-1:0]];
        st.sp_zero     = (sp_reg == '0);
        st.sp_gt1      = (sp_reg > CNT_W'(1));
        st.top_null    = top_reg[PTR_W-1];
        st.t_out_range = ({1'b0, tgt_rd} >= nc);
        st.d_zero      = (deg_cur == '0);
        st.d_one       = (deg_cur == DEG_W'(1));
        st.can_push    = (emitted_reg < NODE_W'(MAX_NODES - 1)) && (sp_reg < NC_MAX);
    end

    assign emit = cmd.scan_emit || cmd.emit_child || cmd.summary;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NC_MAX;
            edges_used_reg <= '0;
            error_reg      <= 1'b0;
            head_valid_reg <= '0;
            hit_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_value;
            end
            if (cmd.reject)
            begin
                error_reg <= 1'b1;
            end
            if (cmd.load2)
            begin
                edges_used_reg        <= edges_used_reg + DEG_W'(1);
                head_valid_reg[s_reg] <= 1'b1;
                hit_reg[t_reg]        <= 1'b1;
            end
            // Clear the graph store once the summary item is out
            if (cmd.summary)
            begin
                edges_used_reg <= '0;
                error_reg      <= 1'b0;
                head_valid_reg <= '0;
                hit_reg        <= '0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load1)
        begin
            s_reg <= in_src;
            t_reg <= in_tgt;
            e_reg <= edges_used_reg[EDGE_W-1:0];
        end
        if (cmd.run_start)
        begin
            scan_reg    <= CNT_W'(1);
            sp_reg      <= '0;
            emitted_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + CNT_W'(1);
        end
        if (cmd.scan_emit)
        begin
            scan_reg    <= scan_reg + CNT_W'(1);
            sp_reg      <= CNT_W'(1);
            top_reg     <= head_ptr;
            emitted_reg <= emitted_reg + NODE_W'(1);
        end
        if (cmd.pop)
        begin
            sp_reg <= sp_m1;
        end
        if (cmd.popw)
        begin
            top_reg <= stk_rd;
        end
        if (cmd.fetch)
        begin
            top_reg <= nxt_rd;
            t_reg   <= tgt_rd;
        end
        if (cmd.emit_child)
        begin
            sp_reg      <= sp_reg + CNT_W'(1);
            top_reg     <= head_ptr;
            emitted_reg <= emitted_reg + NODE_W'(1);
        end
        if (emit)
        begin
            out_node    <= cmd.scan_emit ? scan_reg[NODE_W-1:0] :
                           (cmd.emit_child ? t_reg : '0);
            out_summary <= cmd.summary;
            out_count   <= cmd.summary ? emitted_reg : '0;
            out_cycle   <= cmd.summary && ({1'b0, emitted_reg} < (nc - CNT_W'(1)));
            out_error   <= cmd.summary && error_reg;
            out_last    <= cmd.summary;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

>>> src/topological_sort_engine.sv
// Top level of the topological sort engine: stream ports, controller and datapath.
`default_nettype none
// Loads directed edges one item at a time (s_tuser = 0) and sorts them on a run
// item (s_tuser = 1). An edge load first reads the source node's list tail and
// the target's in-degree, then appends the edge and bumps the count. Rejected
// edges (store full, node 0, node at or above node_count) set the sticky
// load-error flag. A run scans nodes 1 to node_count-1 in turn and, from each
// node that is no edge's target, walks the successor lists depth first through
// the edge memories before it scans the next node; it stalls while the result
// stream applies backpressure. The emitted nodes come out in order, then one
// summary item with tlast high carrying the sorted count, a cycle flag and the
// load error flag. The graph store is cleared in the same cycle the summary
// item is produced, so no clearing pass follows. node_count is written through
// cfg by the user only at idle times (the block does not enforce this) and is
// clamped to 2..64.
module topological_sort_engine import tse_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,      // node_count
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,       // [5:0] source_node, [11:6] target_node
    input  wire logic        s_tuser,       // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,       // [5:0] node, [11:6] sorted_count,
                                            // [12] has_cycle, [13] load_error
    output logic             m_tuser,       // is_summary
    output logic             m_tlast        // last
);
    cmd_t              cmd;
    stat_t             st;
    logic [NODE_W-1:0] out_node;
    logic [NODE_W-1:0] out_count;
    logic              out_cycle;
    logic              out_error;

    // Configuration is always taken at once
    assign cfg_ready = 1'b1;

    tse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_ready  (s_tready),
        .st        (st),
        .cmd       (cmd)
    );

    tse_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .cfg_we      (cfg_valid),
        .cfg_value   (cfg_data),
        .in_src      (s_tdata[5:0]),
        .in_tgt      (s_tdata[11:6]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_node    (out_node),
        .out_summary (m_tuser),
        .out_count   (out_count),
        .out_cycle   (out_cycle),
        .out_error   (out_error),
        .out_last    (m_tlast)
    );

    // Pack result fields from the lowest bit up
    assign m_tdata = {2'b00, out_error, out_cycle, out_count, out_node};
endmodule
`default_nettype wire
